[hw/rtl/s512h_pkg.sv]
// ----------------------------------------------------------------------------
// s512h_pkg
// Shared types, round constants and initial values for the SHA-512/384 hasher.
// ----------------------------------------------------------------------------
package s512h_pkg;

  typedef enum logic [1:0] {
    SEL_DATA,
    SEL_PAD,
    SEL_ZERO,
    SEL_LEN
  } push_sel_t;

  typedef struct packed {
    logic       push;
    push_sel_t  sel;
    logic       round;
    logic [6:0] round_idx;
    logic       finish;
    logic       restart;
    logic [2:0] out_idx;
  } cmd_t;

  typedef struct packed {
    logic cnt_full;
    logic cnt_len;
    logic full_word;
    logic out_last;
  } status_t;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  function automatic logic [63:0] iv_word(input logic mode, input logic [2:0] idx);
    logic [63:0] r;
    unique case (idx)
      3'd0: r = mode ? 64'hCBBB9D5DC1059ED8 : 64'h6A09E667F3BCC908;
      3'd1: r = mode ? 64'h629A292A367CD507 : 64'hBB67AE8584CAA73B;
      3'd2: r = mode ? 64'h9159015A3070DD17 : 64'h3C6EF372FE94F82B;
      3'd3: r = mode ? 64'h152FECD8F70E5939 : 64'hA54FF53A5F1D36F1;
      3'd4: r = mode ? 64'h67332667FFC00B31 : 64'h510E527FADE682D1;
      3'd5: r = mode ? 64'h8EB44A8768581511 : 64'h9B05688C2B3E6C1F;
      3'd6: r = mode ? 64'hDB0C2E0D64F98FA7 : 64'h1F83D9ABFB41BD6B;
      default: r = mode ? 64'h47B5481DBEFA4FA4 : 64'h5BE0CD19137E2179;
    endcase
    return r;
  endfunction

  function automatic logic [63:0] round_k(input logic [6:0] i);
    logic [63:0] r;
    case (i)
      7'd0: r = 64'h428A2F98D728AE22;  7'd1: r = 64'h7137449123EF65CD;
      7'd2: r = 64'hB5C0FBCFEC4D3B2F;  7'd3: r = 64'hE9B5DBA58189DBBC;
      7'd4: r = 64'h3956C25BF348B538;  7'd5: r = 64'h59F111F1B605D019;
      7'd6: r = 64'h923F82A4AF194F9B;  7'd7: r = 64'hAB1C5ED5DA6D8118;
      7'd8: r = 64'hD807AA98A3030242;  7'd9: r = 64'h12835B0145706FBE;
      7'd10: r = 64'h243185BE4EE4B28C; 7'd11: r = 64'h550C7DC3D5FFB4E2;
      7'd12: r = 64'h72BE5D74F27B896F; 7'd13: r = 64'h80DEB1FE3B1696B1;
      7'd14: r = 64'h9BDC06A725C71235; 7'd15: r = 64'hC19BF174CF692694;
      7'd16: r = 64'hE49B69C19EF14AD2; 7'd17: r = 64'hEFBE4786384F25E3;
      7'd18: r = 64'h0FC19DC68B8CD5B5; 7'd19: r = 64'h240CA1CC77AC9C65;
      7'd20: r = 64'h2DE92C6F592B0275; 7'd21: r = 64'h4A7484AA6EA6E483;
      7'd22: r = 64'h5CB0A9DCBD41FBD4; 7'd23: r = 64'h76F988DA831153B5;
      7'd24: r = 64'h983E5152EE66DFAB; 7'd25: r = 64'hA831C66D2DB43210;
      7'd26: r = 64'hB00327C898FB213F; 7'd27: r = 64'hBF597FC7BEEF0EE4;
      7'd28: r = 64'hC6E00BF33DA88FC2; 7'd29: r = 64'hD5A79147930AA725;
      7'd30: r = 64'h06CA6351E003826F; 7'd31: r = 64'h142929670A0E6E70;
      7'd32: r = 64'h27B70A8546D22FFC; 7'd33: r = 64'h2E1B21385C26C926;
      7'd34: r = 64'h4D2C6DFC5AC42AED; 7'd35: r = 64'h53380D139D95B3DF;
      7'd36: r = 64'h650A73548BAF63DE; 7'd37: r = 64'h766A0ABB3C77B2A8;
      7'd38: r = 64'h81C2C92E47EDAEE6; 7'd39: r = 64'h92722C851482353B;
      7'd40: r = 64'hA2BFE8A14CF10364; 7'd41: r = 64'hA81A664BBC423001;
      7'd42: r = 64'hC24B8B70D0F89791; 7'd43: r = 64'hC76C51A30654BE30;
      7'd44: r = 64'hD192E819D6EF5218; 7'd45: r = 64'hD69906245565A910;
      7'd46: r = 64'hF40E35855771202A; 7'd47: r = 64'h106AA07032BBD1B8;
      7'd48: r = 64'h19A4C116B8D2D0C8; 7'd49: r = 64'h1E376C085141AB53;
      7'd50: r = 64'h2748774CDF8EEB99; 7'd51: r = 64'h34B0BCB5E19B48A8;
      7'd52: r = 64'h391C0CB3C5C95A63; 7'd53: r = 64'h4ED8AA4AE3418ACB;
      7'd54: r = 64'h5B9CCA4F7763E373; 7'd55: r = 64'h682E6FF3D6B2B8A3;
      7'd56: r = 64'h748F82EE5DEFB2FC; 7'd57: r = 64'h78A5636F43172F60;
      7'd58: r = 64'h84C87814A1F0AB72; 7'd59: r = 64'h8CC702081A6439EC;
      7'd60: r = 64'h90BEFFFA23631E28; 7'd61: r = 64'hA4506CEBDE82BDE9;
      7'd62: r = 64'hBEF9A3F7B2C67915; 7'd63: r = 64'hC67178F2E372532B;
      7'd64: r = 64'hCA273ECEEA26619C; 7'd65: r = 64'hD186B8C721C0C207;
      7'd66: r = 64'hEADA7DD6CDE0EB1E; 7'd67: r = 64'hF57D4F7FEE6ED178;
      7'd68: r = 64'h06F067AA72176FBA; 7'd69: r = 64'h0A637DC5A2C898A6;
      7'd70: r = 64'h113F9804BEF90DAE; 7'd71: r = 64'h1B710B35131C471B;
      7'd72: r = 64'h28DB77F523047D84; 7'd73: r = 64'h32CAAB7B40C72493;
      7'd74: r = 64'h3C9EBE0A15C9BEBC; 7'd75: r = 64'h431D67C49C100D4C;
      7'd76: r = 64'h4CC5D4BECB3E42B6; 7'd77: r = 64'h597F299CFC657E2A;
      7'd78: r = 64'h5FCB6FAB3AD6FAEC; 7'd79: r = 64'h6C44198C4A475817;
      default: r = 64'h0;
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/s512h_ctrl.sv]
// ----------------------------------------------------------------------------
// s512h_ctrl
// Sequencer: word intake, padding, 80-round compression and digest readout.
// ----------------------------------------------------------------------------
module s512h_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              last_word,
  output logic              out_valid,
  input  logic              out_stall,
  input  s512h_pkg::status_t sts,
  output s512h_pkg::cmd_t    cmd
);
  import s512h_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMP,
    ST_FIN,
    ST_PAD,
    ST_LEN,
    ST_OUT
  } state_t;

  state_t     state, ret;
  logic [6:0] round;
  logic [2:0] out_idx;
  logic       pad_done;
  logic       in_xfer;

  assign in_stall  = (state != ST_IDLE);
  assign out_valid = (state == ST_OUT);
  assign in_xfer   = in_valid && (state == ST_IDLE);

  always_comb begin
    cmd           = '0;
    cmd.sel       = SEL_DATA;
    cmd.round_idx = round;
    cmd.out_idx   = out_idx;
    unique case (state)
      ST_IDLE: cmd.push = in_xfer;
      ST_COMP: cmd.round = 1'b1;
      ST_FIN:  cmd.finish = 1'b1;
      ST_PAD: begin
        cmd.push = 1'b1;
        if (!pad_done) cmd.sel = SEL_PAD;
        else cmd.sel = SEL_ZERO;
      end
      ST_LEN: begin
        cmd.push = 1'b1;
        cmd.sel  = SEL_LEN;
      end
      ST_OUT:  cmd.restart = !out_stall && sts.out_last;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      ret      <= ST_IDLE;
      round    <= '0;
      out_idx  <= '0;
      pad_done <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            pad_done <= last_word && !sts.full_word;
            round    <= '0;
            if (sts.cnt_full) begin
              state <= ST_COMP;
              ret   <= last_word ? ST_PAD : ST_IDLE;
            end else if (last_word) begin
              state <= ST_PAD;
            end
          end
        end
        ST_COMP: begin
          round <= round + 7'd1;
          if (round == 7'd79) state <= ST_FIN;
        end
        ST_FIN: state <= ret;
        ST_PAD: begin
          pad_done <= 1'b1;
          round    <= '0;
          if (sts.cnt_full) begin
            state <= ST_COMP;
            ret   <= ST_PAD;
          end else if (pad_done && sts.cnt_len) begin
            // upper length word just went in as zero
            state <= ST_LEN;
          end
        end
        ST_LEN: begin
          round   <= '0;
          out_idx <= '0;
          state   <= ST_COMP;
          ret     <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_stall) begin
            out_idx <= out_idx + 3'd1;
            if (sts.out_last) state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[hw/rtl/s512h_dp.sv]
// ----------------------------------------------------------------------------
// s512h_dp
// Datapath: block words, message schedule, working variables and chain state.
// ----------------------------------------------------------------------------
module s512h_dp (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_data,
  input  logic [63:0]        message_word,
  input  logic [3:0]         valid_bytes,
  input  logic               last_word,
  input  s512h_pkg::cmd_t    cmd,
  output s512h_pkg::status_t sts,
  output logic [63:0]        digest_word,
  output logic [2:0]         word_index,
  output logic               last_of_digest
);
  import s512h_pkg::*;

  logic        mode;
  logic [63:0] w [16];
  logic [63:0] hsh [8];
  logic [63:0] v [8];
  logic [3:0]  cnt;
  logic [63:0] bit_count;
  logic [3:0]  n_eff;
  logic [63:0] data_word, push_word, w_new, t1, t2;
  logic [63:0] s0, s1, e_sig, a_sig, ch, maj;

  assign n_eff = (!last_word || valid_bytes > 4'd8) ? 4'd8 : valid_bytes;

  // keep the valid leading bytes, pad byte right after them on a short last word
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < n_eff) data_word[63 - 8*i -: 8] = message_word[63 - 8*i -: 8];
      else if (4'(i) == n_eff) data_word[63 - 8*i -: 8] = PAD_BYTE;
      else data_word[63 - 8*i -: 8] = 8'h00;
    end
  end

  always_comb begin
    unique case (cmd.sel)
      SEL_DATA: push_word = data_word;
      SEL_PAD:  push_word = {PAD_BYTE, 56'h0};
      SEL_ZERO: push_word = 64'h0;
      SEL_LEN:  push_word = bit_count;
      default:  push_word = 64'h0;
    endcase
  end

  assign s0    = {w[1][0], w[1][63:1]} ^ {w[1][7:0], w[1][63:8]} ^ (w[1] >> 7);
  assign s1    = {w[14][18:0], w[14][63:19]} ^ {w[14][60:0], w[14][63:61]} ^ (w[14] >> 6);
  assign w_new = s1 + w[9] + s0 + w[0];

  assign e_sig = {v[4][13:0], v[4][63:14]} ^ {v[4][17:0], v[4][63:18]}
               ^ {v[4][40:0], v[4][63:41]};
  assign a_sig = {v[0][27:0], v[0][63:28]} ^ {v[0][33:0], v[0][63:34]}
               ^ {v[0][38:0], v[0][63:39]};
  assign ch    = v[6] ^ (v[4] & (v[5] ^ v[6]));
  assign maj   = (v[0] & v[1]) | (v[2] & (v[0] ^ v[1]));
  assign t1    = v[7] + e_sig + ch + round_k(cmd.round_idx) + w[0];
  assign t2    = a_sig + maj;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= 1'b0;
      cnt       <= '0;
      bit_count <= '0;
      for (int i = 0; i < 8; i++) hsh[i] <= iv_word(1'b0, 3'(i));
    end else if (cfg_we) begin
      mode      <= cfg_data;
      cnt       <= '0;
      bit_count <= '0;
      for (int i = 0; i < 8; i++) hsh[i] <= iv_word(cfg_data, 3'(i));
    end else if (cmd.restart) begin
      cnt       <= '0;
      bit_count <= '0;
      for (int i = 0; i < 8; i++) hsh[i] <= iv_word(mode, 3'(i));
    end else if (cmd.push) begin
      cnt <= cnt + 4'd1;
      if (cmd.sel == SEL_DATA) bit_count <= bit_count + {57'h0, n_eff, 3'b000};
    end else if (cmd.finish) begin
      cnt <= '0;
      for (int i = 0; i < 8; i++) hsh[i] <= hsh[i] + v[i];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      w[cnt] <= push_word;
      for (int i = 0; i < 8; i++) v[i] <= hsh[i];
    end else if (cmd.round) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= w_new;
      v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
      v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
    end
  end

  assign sts.cnt_full  = (cnt == 4'd15);
  assign sts.cnt_len   = (cnt == 4'd14);
  assign sts.full_word = (n_eff == 4'd8);
  assign sts.out_last  = (cmd.out_idx == (mode ? 3'd5 : 3'd7));

  assign digest_word    = hsh[cmd.out_idx];
  assign word_index     = cmd.out_idx;
  assign last_of_digest = sts.out_last;

endmodule

[hw/rtl/sha512_stream_hasher_unit.sv]
// ----------------------------------------------------------------------------
// sha512_stream_hasher_unit
// SHA-512 / SHA-384 hash over a stream of big-endian 64-bit message words.
// ----------------------------------------------------------------------------
// Input channel: message_word, valid_bytes, last_word with in_valid/in_stall.
// Every sixteenth word of a block starts the compression, 80 rounds at one
// per cycle followed by the chain update, during which in_stall stays high;
// the next block's words wait on the single shared round unit.
// On a last word the unit pads with 0x80, zeros and the 64-bit bit count,
// one padding word a cycle, with one or two more compressions.
// It then presents 8 (SHA-512) or 6 (SHA-384) digest words, one a cycle, on
// out_valid/out_stall, index 0 first, last_of_digest on the final one.
// While the receiver stalls, the current digest word holds and no input is
// taken. After the final digest transfer the initial values reload.
// cfg_we writes digest_mode from cfg_data; it restarts the message and loads
// the mode's initial values. Reset selects SHA-512 with an empty message.
module sha512_stream_hasher_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] message_word,
  input  logic [3:0]  valid_bytes,
  input  logic        last_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_of_digest
);
  import s512h_pkg::*;

  cmd_t    cmd;
  status_t sts;

  s512h_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .last_word (last_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  s512h_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .message_word   (message_word),
    .valid_bytes    (valid_bytes),
    .last_word      (last_word),
    .cmd            (cmd),
    .sts            (sts),
    .digest_word    (digest_word),
    .word_index     (word_index),
    .last_of_digest (last_of_digest)
  );

endmodule

[hw/rtl/s512h_checker.sv]
// ----------------------------------------------------------------------------
// s512h_checker
// Port-level checks on the digest readout of the hasher.
// ----------------------------------------------------------------------------
module s512h_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] word_index,
  input logic       last_of_digest
);

  // no input transfer while a digest is being read out
  a_stall_during_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input open during digest readout");

  a_first_index: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> word_index == 3'd0) else $error("digest not starting at 0");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_of_digest) |-> (word_index == 3'd5 || word_index == 3'd7))
    else $error("bad final digest index");

  a_end_of_digest: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && last_of_digest) |=> !out_valid)
    else $error("digest runs past its final word");

endmodule

bind sha512_stream_hasher_unit s512h_checker u_checker (
  .clk            (clk),
  .rst            (rst),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .word_index     (word_index),
  .last_of_digest (last_of_digest)
);
